FILE: src/dfa_alp_pkg.sv
// ----------------------------------------------------------------------------
// dfa_alp_pkg
// Shared types and constants for the longest-prefix automaton recognizer.
// ----------------------------------------------------------------------------
package dfa_alp_pkg;

    // Fixed field widths of the stream items
    localparam int SYM_W   = 8;
    localparam int STATE_W = 4;
    localparam int OUT_LEN_W = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Configuration register indexes
    localparam logic CFG_START_STATE = 1'b0;
    localparam logic CFG_FINAL_MASK  = 1'b1;
    localparam int   CFG_DATA_W      = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified input beat
    typedef struct packed {
        logic               is_load;
        logic [SYM_W-1:0]   symbol;
        logic               last;
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] to_state;
        logic               entry_defined;
    } cmd_t;

    // One transition table entry
    typedef struct packed {
        logic               defined;
        logic [STATE_W-1:0] to_state;
    } entry_t;

endpackage

FILE: src/dfa_alp_front.sv
// ----------------------------------------------------------------------------
// dfa_alp_front
// Input stage: registers each beat, classifies it and drops loads whose
// source state is out of range before they reach the command queue.
// ----------------------------------------------------------------------------
module dfa_alp_front
    import dfa_alp_pkg::*;
#(
    parameter int NUM_STATES = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic busy,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // symbol, from_state, to_state, entry_defined
    input  logic s_tuser,                  // func
    input  logic s_tlast,                  // last
    output logic q_push,
    output cmd_t q_cmd,
    input  logic q_full
);

    logic hold_valid_reg, hold_valid_next;
    cmd_t hold_reg, hold_next;
    cmd_t in_cmd;
    logic drop;
    logic leave;

    // Unpack the incoming beat
    always_comb begin
        in_cmd.is_load       = ~s_tuser;
        in_cmd.symbol        = s_tdata[7:0];
        in_cmd.last          = s_tlast;
        in_cmd.from_state    = s_tdata[11:8];
        in_cmd.to_state      = s_tdata[15:12];
        in_cmd.entry_defined = s_tdata[16];
    end

    // Classify the held beat: loads from a source state with no row are discarded
    assign drop   = hold_reg.is_load && !(32'(hold_reg.from_state) < NUM_STATES);
    assign leave  = hold_valid_reg && (drop || !q_full);
    assign q_push = hold_valid_reg && !drop && !q_full;
    assign q_cmd  = hold_reg;

    assign s_tready = !busy && (!hold_valid_reg || leave);

    // Advance the holding register
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (leave) begin
            hold_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            hold_valid_next = 1'b1;
            hold_next       = in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_reg <= hold_next;
    end

endmodule

FILE: src/dfa_alp_queue.sv
// ----------------------------------------------------------------------------
// dfa_alp_queue
// Short command queue that decouples the input stage from the engine.
// ----------------------------------------------------------------------------
module dfa_alp_queue
    import dfa_alp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/dfa_alp_engine.sv
// ----------------------------------------------------------------------------
// dfa_alp_engine
// Back end: owns the transition memory, clears it after reset, applies loads
// and steps the automaton one symbol per lookup, then registers the result.
// ----------------------------------------------------------------------------
module dfa_alp_engine
    import dfa_alp_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8,
    parameter int LEN_BITS    = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic [STATE_W-1:0] start_state,
    input  logic [15:0] final_mask,
    input  logic q_empty,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic busy,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // accepted, max_prefix_len, stuck, end_state
);

    // Only states reachable through a 4-bit state number get a table row
    localparam int ROWS  = (NUM_STATES < 16) ? NUM_STATES : 16;
    localparam int RB    = $clog2(ROWS);
    localparam int AW    = RB + SYMBOL_BITS;
    localparam int DEPTH = ROWS << SYMBOL_BITS;
    localparam int WB    = (LEN_BITS > OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    entry_t mem [DEPTH];

    logic [1:0] st_reg, st_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [STATE_W-1:0] cur_state_reg, cur_state_next;
    logic in_word_reg, in_word_next;
    logic dead_reg, dead_next;
    logic [LEN_BITS-1:0] word_len_reg, word_len_next;
    logic [LEN_BITS-1:0] best_len_reg, best_len_next;
    logic last_reg, last_next;
    logic rng_ok_reg, rng_ok_next;
    logic out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    entry_t wr_data;
    logic rd_en;
    logic [AW-1:0] rd_addr;
    entry_t rd_data_reg;

    logic [STATE_W-1:0] eff_state;
    logic [LEN_BITS-1:0] len_inc;
    logic [WB-1:0] best_wide;
    logic [OUT_LEN_W-1:0] best_out;
    logic can_out;

    assign busy     = (st_reg == ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign eff_state = in_word_reg ? cur_state_reg : start_state;
    assign can_out   = !out_valid_reg || m_tready;
    assign len_inc   = (&word_len_reg) ? word_len_reg : word_len_reg + 1'b1;

    // Main sequencer
    always_comb begin
        st_next        = st_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_state_next = cur_state_reg;
        in_word_next   = in_word_reg;
        dead_next      = dead_reg;
        word_len_next  = word_len_reg;
        best_len_next  = best_len_reg;
        last_next      = last_reg;
        rng_ok_next    = rng_ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_cnt_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = {eff_state[RB-1:0], q_cmd.symbol[SYMBOL_BITS-1:0]};
        q_pop          = 1'b0;
        best_wide      = '0;
        best_out       = '0;

        // Drop the result once the sink takes it
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH-1)) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_cmd.is_load) begin
                        // Write or remove one transition entry
                        wr_en   = 1'b1;
                        wr_addr = {q_cmd.from_state[RB-1:0], q_cmd.symbol[SYMBOL_BITS-1:0]};
                        wr_data = q_cmd.entry_defined ? {1'b1, q_cmd.to_state} : '0;
                    end else begin
                        // Open a word if needed and issue the lookup
                        if (!in_word_reg) begin
                            dead_next     = 1'b0;
                            word_len_next = '0;
                            best_len_next = '0;
                        end
                        in_word_next   = 1'b1;
                        cur_state_next = eff_state;
                        rng_ok_next    = (32'(eff_state) < NUM_STATES);
                        rd_en          = (32'(eff_state) < NUM_STATES);
                        last_next      = q_cmd.last;
                        st_next        = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (!last_reg || can_out) begin
                    // Step on a defined entry, else the word is stuck
                    if (!dead_reg) begin
                        if (rng_ok_reg && rd_data_reg.defined) begin
                            cur_state_next = rd_data_reg.to_state;
                            word_len_next  = len_inc;
                            if (final_mask[rd_data_reg.to_state]) begin
                                best_len_next = len_inc;
                            end
                        end else begin
                            dead_next = 1'b1;
                        end
                    end
                    if (last_reg) begin
                        best_wide = WB'(best_len_next);
                        best_out  = (best_wide > WB'(16'hFFFF)) ? 16'hFFFF
                                                                : best_wide[OUT_LEN_W-1:0];
                        out_data_next = {2'b00, cur_state_next, dead_next, best_out,
                                         !dead_next && final_mask[cur_state_next]};
                        out_valid_next = 1'b1;
                        in_word_next   = 1'b0;
                    end
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            in_word_reg   <= 1'b0;
            dead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            clr_cnt_reg   <= clr_cnt_next;
            in_word_reg   <= in_word_next;
            dead_reg      <= dead_next;
            out_valid_reg <= out_valid_next;
        end
        cur_state_reg <= cur_state_next;
        word_len_reg  <= word_len_next;
        best_len_reg  <= best_len_next;
        last_reg      <= last_next;
        rng_ok_reg    <= rng_ok_next;
        out_data_reg  <= out_data_next;
    end

    // Transition memory write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Transition memory read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: src/dfa_accept_longest_prefix_top.sv
// ----------------------------------------------------------------------------
// dfa_accept_longest_prefix_top
// Table-driven automaton recognizer reporting acceptance and the longest
// accepted prefix of each word.
//
//   channel  direction  beat contents
//   s_       in         tuser=func, tlast=last, tdata=symbol/from/to/defined
//   m_       out        tdata=accepted/max_prefix_len/stuck/end_state
//   cfg_     in         index 0 start_state, index 1 final_mask
//
// A symbol beat goes through the table read, then the step; a load beat is
// applied from the idle state alone. The registered read of the transition
// memory sets the symbol rate. After reset a clearing pass writes every
// table entry, one per cycle, with s_tready low. A pending result waits in
// the output register while input beats keep flowing into the command
// queue; the engine stalls only on the last symbol of a word when that
// register is still full.
// ----------------------------------------------------------------------------
module dfa_accept_longest_prefix_top
    import dfa_alp_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8,
    parameter int LEN_BITS    = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] symbol, [11:8] from_state,
                                           // [15:12] to_state, [16] entry_defined
    input  logic s_tuser,                  // [0] func
    input  logic s_tlast,                  // last
    output logic m_tvalid,
    input  logic m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [0] accepted, [16:1] max_prefix_len,
                                           // [17] stuck, [21:18] end_state
    input  logic cfg_wr_en,
    input  logic cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [STATE_W-1:0] start_state_reg;
    logic [15:0] final_mask_reg;
    logic busy;
    logic q_push, q_full, q_pop, q_empty;
    cmd_t push_cmd, pop_cmd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= '0;
            final_mask_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_STATE: start_state_reg <= cfg_wdata[STATE_W-1:0];
                CFG_FINAL_MASK:  final_mask_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    dfa_alp_front #(
        .NUM_STATES (NUM_STATES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .busy     (busy),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .q_full   (q_full)
    );

    dfa_alp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    dfa_alp_engine #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS),
        .LEN_BITS    (LEN_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_state (start_state_reg),
        .final_mask  (final_mask_reg),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .busy        (busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
